[hdl/ifs_pkg.sv]
// ifs_pkg: shared types, codes and the separator classifier of the IFS field splitter.
// No dependencies; every other file of the block depends on it.
`timescale 1ns / 1ps

package ifs_pkg;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   // Splitter state
   typedef enum logic [1:0] {
      MODE_LEAD  = 2'd0,
      MODE_FIELD = 2'd1,
      MODE_SOFT  = 2'd2,
      MODE_HARD  = 2'd3
   } mode_type;

   // Byte classes
   typedef enum logic [1:0] {
      CLS_PLAIN = 2'd0,
      CLS_SOFT  = 2'd1,
      CLS_HARD  = 2'd2
   } class_type;

   // Register indexes of the control port
   localparam logic [2:0] CSR_SEP_COUNT  = 3'd0;
   localparam logic [2:0] CSR_SEP_CHAR_A = 3'd1;
   localparam logic [2:0] CSR_SEP_CHAR_B = 3'd2;
   localparam logic [2:0] CSR_SEP_CHAR_C = 3'd3;
   localparam logic [2:0] CSR_SEP_CHAR_D = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam int SEP_SLOTS = 4;
   localparam logic [2:0] SEP_COUNT_RESET = 3'd3;
   localparam logic [SEP_SLOTS-1:0][7:0] SEP_CHARS_RESET = {8'd0, 8'd10, 8'd9, 8'd32};

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // Results per item and result queue depth
   localparam int MAX_RESULTS  = 3;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int PUSH_CNT_W   = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      kind_type   kind;
      logic [7:0] field_byte;
      logic       run_last;
   } rsp_item_type;

   typedef struct packed {
      logic [PUSH_CNT_W-1:0]                n;
      rsp_item_type [MAX_RESULTS-1:0]       items;
   } push_bundle_type;

   function automatic logic is_space_class(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE);
   endfunction

   // Counts above the slot count act as the slot count; duplicates are harmless.
   function automatic class_type classify(input logic [7:0] c,
                                          input logic [2:0] count,
                                          input logic [SEP_SLOTS-1:0][7:0] chars);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < SEP_SLOTS; i++) begin
         if ((count > 3'(i)) && (c == chars[i])) begin
            hit = 1'b1;
         end
      end
      if (!hit) begin
         return CLS_PLAIN;
      end
      return is_space_class(c) ? CLS_SOFT : CLS_HARD;
   endfunction

endpackage

[hdl/ifs_if.sv]
// ifs_req_if / ifs_rsp_if: valid/ready channels for text bytes and split results.
// Depends on ifs_pkg for the result kind type.
`timescale 1ns / 1ps

interface ifs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       text_last;

   modport source (output valid, output text_byte, output text_last, input ready);
   modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface ifs_rsp_if;
   logic              valid;
   logic              ready;
   ifs_pkg::kind_type kind;
   logic [7:0]        field_byte;
   logic              run_last;

   modport source (output valid, output kind, output field_byte, output run_last,
                   input ready);
   modport sink   (input valid, input kind, input field_byte, input run_last,
                   output ready);
endinterface

[hdl/ifs_split_core.sv]
// ifs_split_core: input register, separator registers and split state; turns one byte
// into up to three results per cycle while the queue has room. Depends on ifs_pkg and ifs_req_if.
`timescale 1ns / 1ps

module ifs_split_core (
   input  logic                          clock,
   input  logic                          reset,
   ifs_req_if.sink                       req_chan,
   input  logic                          csr_we,
   input  logic [ifs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ifs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                          room,
   output ifs_pkg::push_bundle_type      push
);
   import ifs_pkg::*;

   logic                        in_valid_ff;
   logic [7:0]                  in_byte_ff;
   logic                        in_last_ff;
   mode_type                    mode_ff, mode_in;
   logic [2:0]                  sep_count_ff;
   logic [SEP_SLOTS-1:0][7:0]   sep_chars_ff;

   logic                        advance;
   logic                        take;
   class_type                   cls;
   rsp_item_type [MAX_RESULTS-1:0] res;
   logic [PUSH_CNT_W-1:0]       n;

   assign advance        = in_valid_ff && room;
   assign req_chan.ready = !in_valid_ff || room;
   assign take           = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (take) begin
         in_byte_ff <= req_chan.text_byte;
         in_last_ff <= req_chan.text_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LEAD;
      end else if (advance) begin
         mode_ff <= mode_in;
      end
   end

   // Separator registers; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_count_ff <= SEP_COUNT_RESET;
         sep_chars_ff <= SEP_CHARS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEP_COUNT:  sep_count_ff    <= csr_wdata[2:0];
            CSR_SEP_CHAR_A: sep_chars_ff[0] <= csr_wdata;
            CSR_SEP_CHAR_B: sep_chars_ff[1] <= csr_wdata;
            CSR_SEP_CHAR_C: sep_chars_ff[2] <= csr_wdata;
            CSR_SEP_CHAR_D: sep_chars_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cls = classify(in_byte_ff, sep_count_ff, sep_chars_ff);

   always_comb begin
      res     = '0;
      n       = '0;
      mode_in = mode_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i].kind = KIND_BYTE;
      end
      case (cls)
         CLS_PLAIN: begin
            res[0].kind       = KIND_BYTE;
            res[0].field_byte = in_byte_ff;
            n                 = PUSH_CNT_W'(1);
            mode_in           = MODE_FIELD;
         end
         CLS_SOFT: begin
            if (mode_ff == MODE_FIELD) begin
               res[0].kind = KIND_END;
               n           = PUSH_CNT_W'(1);
               mode_in     = MODE_SOFT;
            end
         end
         default: begin
            // hard separator: joins a pending soft delimiter, else ends a field
            if (mode_ff != MODE_SOFT) begin
               res[0].kind = KIND_END;
               n           = PUSH_CNT_W'(1);
            end
            mode_in = MODE_HARD;
         end
      endcase
      if (in_last_ff) begin
         if (mode_in == MODE_FIELD) begin
            res[n[1:0]].kind = KIND_END;
            n                = n + PUSH_CNT_W'(1);
         end
         res[n[1:0]].kind = KIND_DONE;
         n                = n + PUSH_CNT_W'(1);
         mode_in          = MODE_LEAD;
      end
      if (n != '0) begin
         res[n[1:0] - 2'd1].run_last = 1'b1;
      end
   end

   assign push.n     = advance ? n : '0;
   assign push.items = res;

endmodule

[hdl/ifs_rsp_queue.sv]
// ifs_rsp_queue: small result queue taking up to three results per cycle, giving one while ready.
// Depends on ifs_pkg and ifs_rsp_if.
`timescale 1ns / 1ps

module ifs_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  ifs_pkg::push_bundle_type push,
   output logic                     room,
   ifs_rsp_if.source                rsp_chan
);
   import ifs_pkg::*;

   rsp_item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wp_ff, rp_ff;
   logic [QUEUE_CNT_W-1:0]       count_ff, count_in, after_pop;
   logic                         pop;
   rsp_item_type                 head;

   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign after_pop = count_ff - QUEUE_CNT_W'(pop);
   assign room      = (after_pop <= QUEUE_CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
   assign count_in  = after_pop + QUEUE_CNT_W'(push.n);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_ff + QUEUE_PTR_W'(push.n);
         rp_ff    <= rp_ff + QUEUE_PTR_W'(pop);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (PUSH_CNT_W'(i) < push.n) begin
            mem_ff[wp_ff + QUEUE_PTR_W'(i)] <= push.items[i];
         end
      end
   end

   assign head                = mem_ff[rp_ff];
   assign rsp_chan.valid      = (count_ff != '0);
   assign rsp_chan.kind       = head.kind;
   assign rsp_chan.field_byte = head.field_byte;
   assign rsp_chan.run_last   = head.run_last;

endmodule

[hdl/ifs_field_splitter_unit.sv]
// An accepted item is held in the input register, split once the queue has room, and its
// results are written into the result queue, which offers the first on the result channel.
// Throughput: one item per cycle while results drain at one per cycle; an item that
// yields two or three results holds the input while the four-entry result queue
// drains them. Items that yield nothing pass at one per cycle while the queue has room.
// Reset (synchronous): queue empty, state leading skip, separators space/tab/newline.
`timescale 1ns / 1ps

module ifs_field_splitter_unit (
   input  logic                            clock,
   input  logic                            reset,
   ifs_req_if.sink                         req_chan,
   ifs_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [ifs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ifs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ifs_pkg::*;

   // Results of one item travel as a bundle from the splitter into the queue.
   push_bundle_type push;
   logic            room;

   // Register the byte, classify it against the separator set and advance the
   // split state; hold the byte while the queue lacks room for three results.
   ifs_split_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .room      (room),
      .push      (push)
   );

   // Buffer results so the input keeps moving while a result waits downstream.
   ifs_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule
